// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the led strip frame store.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/lsfs_pkg.sv =====
// ----------------------------------------------------------------------------
// lsfs_pkg
// Constants, codes and controller/datapath interface types of the frame store.
// ----------------------------------------------------------------------------
package lsfs_pkg;

  // store geometry
  localparam int MAX_LEDS    = 256;
  localparam int MAX_STRIPS  = 8;
  localparam int END_WORDS   = 30;
  localparam int STORE_DEPTH = MAX_LEDS * MAX_STRIPS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // effective count widths
  localparam int LCNT_W = $clog2(MAX_LEDS + 1);
  localparam int SCNT_W = $clog2(MAX_STRIPS + 1);
  localparam int TOT_W  = $clog2(STORE_DEPTH + 1);

  // divider: quotient is a strip number
  localparam int QW  = (MAX_STRIPS > 1) ? $clog2(MAX_STRIPS) : 1;
  localparam int QIW = (QW > 1) ? $clog2(QW) : 1;
  localparam int DW  = ADDR_W + 1;

  // fixed field widths
  localparam int PTR_W        = 12;
  localparam int LEDS_CFG_W   = 9;
  localparam int STRIPS_CFG_W = 4;
  localparam int WORD_W       = 32;
  localparam int COLOR_W      = 24;
  localparam int BRIGHT_W     = 5;
  localparam int CFG_IDX_W    = 2;

  localparam logic [7:0] HEADER_FLAG = 8'hE0;
  localparam logic [WORD_W-1:0] OFF_WORD_RESET = 32'hE000_0000;
  localparam logic [LEDS_CFG_W-1:0] LEDS_RESET = 9'd256;
  localparam logic [STRIPS_CFG_W-1:0] STRIPS_RESET = 4'd8;

  // item commands
  typedef enum logic [2:0] {
    CMD_SET   = 3'd0,
    CMD_BLEND = 3'd1,
    CMD_OFF   = 3'd2,
    CMD_CLEAR = 3'd3,
    CMD_NEXT  = 3'd4
  } lsfs_op_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEDS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIPS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF    = 2'd2;

  // controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_BLEND_RD,
    ST_BLEND_WR,
    ST_FRAME,
    ST_DIV,
    ST_READ,
    ST_PUT
  } lsfs_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic cap;
    logic item_wr;
    logic blend_rd;
    logic blend_wr;
    logic clr_wr;
    logic div_start;
    logic div_step;
    logic frame_rd;
    logic put;
  } lsfs_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic ptr_led;
    logic div_done;
    logic clr_done;
    logic out_free;
  } lsfs_stat_t;

endpackage

// ===== src/lsfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsfs_ctrl
// Sequencer for the frame store: clearing sweep, item writes, read-modify-write
// blends and frame word read-out.
// ----------------------------------------------------------------------------
module lsfs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [2:0]            command,
  input  lsfs_pkg::lsfs_stat_t  stat,
  output logic                  in_stall,
  output lsfs_pkg::lsfs_cmd_t   cmd
);

  lsfs_pkg::lsfs_state_t state;
  lsfs_pkg::lsfs_state_t state_next;

  // state register, reset starts the clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lsfs_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lsfs_pkg::ST_CLEAR: begin
        if (stat.clr_done) begin
          state_next = lsfs_pkg::ST_IDLE;
        end
      end
      lsfs_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (command) inside
            lsfs_pkg::CMD_SET, lsfs_pkg::CMD_OFF: state_next = lsfs_pkg::ST_WRITE;
            lsfs_pkg::CMD_BLEND: state_next = lsfs_pkg::ST_BLEND_RD;
            lsfs_pkg::CMD_CLEAR: state_next = lsfs_pkg::ST_CLEAR;
            lsfs_pkg::CMD_NEXT:  state_next = lsfs_pkg::ST_FRAME;
            default:             state_next = lsfs_pkg::ST_IDLE;
          endcase
        end
      end
      lsfs_pkg::ST_WRITE:    state_next = lsfs_pkg::ST_IDLE;
      lsfs_pkg::ST_BLEND_RD: state_next = lsfs_pkg::ST_BLEND_WR;
      lsfs_pkg::ST_BLEND_WR: state_next = lsfs_pkg::ST_IDLE;
      lsfs_pkg::ST_FRAME: begin
        state_next = stat.ptr_led ? lsfs_pkg::ST_DIV : lsfs_pkg::ST_PUT;
      end
      lsfs_pkg::ST_DIV: begin
        if (stat.div_done) begin
          state_next = lsfs_pkg::ST_READ;
        end
      end
      lsfs_pkg::ST_READ: state_next = lsfs_pkg::ST_PUT;
      lsfs_pkg::ST_PUT: begin
        if (stat.out_free) begin
          state_next = lsfs_pkg::ST_IDLE;
        end
      end
      default: state_next = lsfs_pkg::ST_IDLE;
    endcase
  end

  // datapath commands and input stall
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      lsfs_pkg::ST_CLEAR:    cmd.clr_wr = 1'b1;
      lsfs_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.cap  = in_valid;
      end
      lsfs_pkg::ST_WRITE:    cmd.item_wr = 1'b1;
      lsfs_pkg::ST_BLEND_RD: cmd.blend_rd = 1'b1;
      lsfs_pkg::ST_BLEND_WR: cmd.blend_wr = 1'b1;
      lsfs_pkg::ST_FRAME:    cmd.div_start = stat.ptr_led;
      lsfs_pkg::ST_DIV:      cmd.div_step = 1'b1;
      lsfs_pkg::ST_READ:     cmd.frame_rd = 1'b1;
      lsfs_pkg::ST_PUT:      cmd.put = stat.out_free;
      default: begin
        cmd      = '0;
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// ===== src/lsfs_datapath.sv =====
// ----------------------------------------------------------------------------
// lsfs_datapath
// Configuration registers, item registers, LED word store, frame pointer,
// strip/position divider and result register of the frame store.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lsfs_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  lsfs_pkg::lsfs_cmd_t                    cmd,
  output lsfs_pkg::lsfs_stat_t                   stat,
  // item fields
  input  logic [2:0]                             command,
  input  logic [7:0]                             led_pos,
  input  logic [2:0]                             strip,
  input  logic [lsfs_pkg::BRIGHT_W-1:0]          brightness,
  input  logic [lsfs_pkg::COLOR_W-1:0]           color,
  // configuration writes
  input  logic                                   cfg_valid,
  input  logic [lsfs_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lsfs_pkg::WORD_W-1:0]            cfg_data,
  // result
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [lsfs_pkg::WORD_W-1:0]            frame_word,
  output logic                                   frame_last
);

  // configuration registers
  logic [lsfs_pkg::LEDS_CFG_W-1:0]   leds_cfg;
  logic [lsfs_pkg::STRIPS_CFG_W-1:0] strips_cfg;
  logic [lsfs_pkg::WORD_W-1:0]       off_word;

  // captured item
  logic [2:0]                    op_q;
  logic [7:0]                    pos_q;
  logic [2:0]                    strip_q;
  logic [lsfs_pkg::BRIGHT_W-1:0] bright_q;
  logic [lsfs_pkg::COLOR_W-1:0]  color_q;

  // store
  logic [lsfs_pkg::WORD_W-1:0] mem [lsfs_pkg::STORE_DEPTH];
  logic [lsfs_pkg::WORD_W-1:0] rd_data;
  logic [lsfs_pkg::ADDR_W-1:0] clr_cnt;
  logic                        init_pass;
  logic                        mem_we;
  logic [lsfs_pkg::ADDR_W-1:0] mem_wa;
  logic [lsfs_pkg::WORD_W-1:0] mem_wd;
  logic                        mem_re;
  logic [lsfs_pkg::ADDR_W-1:0] mem_ra;

  // frame read-out
  logic [lsfs_pkg::PTR_W-1:0]  ptr;
  logic [lsfs_pkg::ADDR_W-1:0] div_rem;
  logic [lsfs_pkg::QW-1:0]     div_q;
  logic [lsfs_pkg::QIW-1:0]    div_idx;
  logic [lsfs_pkg::DW-1:0]     div_sub;
  logic                        div_ge;

  // decoded values
  logic [lsfs_pkg::LCNT_W-1:0] eff_leds;
  logic [lsfs_pkg::SCNT_W-1:0] eff_strips;
  logic [lsfs_pkg::TOT_W-1:0]  total;
  logic                        in_rng;
  logic [lsfs_pkg::LCNT_W-1:0] slot;
  logic [lsfs_pkg::ADDR_W-1:0] item_addr;
  logic [lsfs_pkg::ADDR_W-1:0] frame_addr;
  logic [lsfs_pkg::WORD_W-1:0] hdr_color;
  logic                        ptr_zero;
  logic                        ptr_led;
  logic                        ptr_last;
  logic                        clr_done;
  logic                        div_done;
  logic                        out_free;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      leds_cfg   <= lsfs_pkg::LEDS_RESET;
      strips_cfg <= lsfs_pkg::STRIPS_RESET;
      off_word   <= lsfs_pkg::OFF_WORD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        lsfs_pkg::CFG_LEDS:   leds_cfg   <= cfg_data[lsfs_pkg::LEDS_CFG_W-1:0];
        lsfs_pkg::CFG_STRIPS: strips_cfg <= cfg_data[lsfs_pkg::STRIPS_CFG_W-1:0];
        lsfs_pkg::CFG_OFF:    off_word   <= cfg_data;
        default: ;
      endcase
    end
  end

  // counts clamped to the store size
  assign eff_leds = (32'(leds_cfg) > 32'(lsfs_pkg::MAX_LEDS)) ?
                    lsfs_pkg::LCNT_W'(lsfs_pkg::MAX_LEDS) : lsfs_pkg::LCNT_W'(leds_cfg);
  assign eff_strips = (32'(strips_cfg) > 32'(lsfs_pkg::MAX_STRIPS)) ?
                      lsfs_pkg::SCNT_W'(lsfs_pkg::MAX_STRIPS) :
                      lsfs_pkg::SCNT_W'(strips_cfg);
  assign total = lsfs_pkg::TOT_W'(32'(eff_leds) * 32'(eff_strips));

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_q     <= command;
      pos_q    <= led_pos;
      strip_q  <= strip;
      bright_q <= brightness;
      color_q  <= color;
    end
  end

  // item address, even strips mirrored
  assign in_rng = (32'(pos_q) < 32'(eff_leds)) && (32'(strip_q) < 32'(eff_strips));
  assign slot = strip_q[0] ? lsfs_pkg::LCNT_W'(pos_q) :
                (eff_leds - lsfs_pkg::LCNT_W'(1) - lsfs_pkg::LCNT_W'(pos_q));
  assign item_addr = lsfs_pkg::ADDR_W'(32'(strip_q) * 32'(lsfs_pkg::MAX_LEDS) + 32'(slot));
  assign hdr_color = {(lsfs_pkg::HEADER_FLAG | 8'(bright_q)), color_q};

  // store write and read selection
  always_comb begin
    mem_we = 1'b0;
    mem_wa = item_addr;
    mem_wd = off_word;
    if (cmd.clr_wr) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt;
      mem_wd = init_pass ? lsfs_pkg::OFF_WORD_RESET : off_word;
    end else if (cmd.item_wr) begin
      mem_we = in_rng;
      mem_wd = (op_q == lsfs_pkg::CMD_SET) ? hdr_color : off_word;
    end else if (cmd.blend_wr) begin
      mem_we = in_rng;
      mem_wd = rd_data | hdr_color;
    end
    mem_re = cmd.blend_rd || cmd.frame_rd;
    mem_ra = cmd.frame_rd ? frame_addr : item_addr;
  end

  // led word memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= mem[mem_ra];
    end
  end

  // clearing sweep counter, left at zero after each pass
  assign clr_done = (32'(clr_cnt) == lsfs_pkg::STORE_DEPTH - 1);
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt <= clr_done ? '0 : clr_cnt + lsfs_pkg::ADDR_W'(1);
    end
  end

  // the pass after reset fills with the reset off word
  always_ff @(posedge clk) begin
    if (rst) begin
      init_pass <= 1'b1;
    end else if (cmd.clr_wr && clr_done) begin
      init_pass <= 1'b0;
    end
  end

  // frame pointer regions
  assign ptr_zero = (ptr == '0);
  assign ptr_led  = !ptr_zero && (32'(ptr) <= 32'(total));
  assign ptr_last = (32'(ptr) >= 32'(total) + lsfs_pkg::END_WORDS);

  // restoring divide of ptr-1 by the led count, one quotient bit a cycle
  assign div_sub  = lsfs_pkg::DW'(eff_leds) << div_idx;
  assign div_ge   = ({1'b0, div_rem} >= div_sub);
  assign div_done = (div_idx == '0);
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_rem <= lsfs_pkg::ADDR_W'(ptr - lsfs_pkg::PTR_W'(1));
      div_q   <= '0;
      div_idx <= lsfs_pkg::QIW'(lsfs_pkg::QW - 1);
    end else if (cmd.div_step) begin
      if (div_ge) begin
        div_rem        <= div_rem - div_sub[lsfs_pkg::ADDR_W-1:0];
        div_q[div_idx] <= 1'b1;
      end
      if (!div_done) begin
        div_idx <= div_idx - lsfs_pkg::QIW'(1);
      end
    end
  end
  assign frame_addr = lsfs_pkg::ADDR_W'(32'(div_q) * 32'(lsfs_pkg::MAX_LEDS) + 32'(div_rem));

  // frame pointer advance
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (cmd.put) begin
      if (!ptr_zero && !ptr_led && ptr_last) begin
        ptr <= '0;
      end else begin
        ptr <= ptr + lsfs_pkg::PTR_W'(1);
      end
    end
  end

  // result register
  assign out_free = !out_valid || !out_stall;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.put) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.put) begin
      frame_word <= ptr_led ? rd_data : '0;
      frame_last <= !ptr_zero && !ptr_led && ptr_last;
    end
  end

  // status to controller
  always_comb begin
    stat.ptr_led  = ptr_led;
    stat.div_done = div_done;
    stat.clr_done = clr_done;
    stat.out_free = out_free;
  end

  // checks
  `ASSERT_ALWAYS(a_one_mem_access, clk, rst,
                 $onehot0({cmd.clr_wr, cmd.item_wr, cmd.blend_wr, cmd.blend_rd, cmd.frame_rd}))
  `ASSERT_NEXT(a_div_rem_below, clk, rst, cmd.div_step && div_done, 32'(div_rem) < 32'(eff_leds))
  `ASSERT_NEXT(a_last_wraps, clk, rst, cmd.put && !ptr_zero && !ptr_led && ptr_last, ptr == '0)
  `ASSERT_IMPL(a_last_word_zero, clk, rst, out_valid && frame_last, frame_word == '0)

endmodule

// ===== src/led_strip_frame_store_core.sv =====
// Items: set and off write the addressed entry, blend reads the entry and then
// writes it back, clear runs a clearing pass. Next frame word: start and end words
// need no store read; LED words pass the three-step divider for strip and slot and
// one store read. Throughput: one item at a time, one store access per cycle through
// a single port. Reset: a clearing pass writes the reset off word to every entry;
// items are stalled meanwhile, configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// led_strip_frame_store_core
// LED word store for serpentine strips with APA102 frame read-out.
// ----------------------------------------------------------------------------
module led_strip_frame_store_core (
  input  logic                                clk,
  input  logic                                rst,
  // item channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [2:0]                          command,
  input  logic [7:0]                          led_pos,
  input  logic [2:0]                          strip,
  input  logic [lsfs_pkg::BRIGHT_W-1:0]       brightness,
  input  logic [lsfs_pkg::COLOR_W-1:0]        color,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lsfs_pkg::WORD_W-1:0]         frame_word,
  output logic                                frame_last,
  // configuration channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lsfs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lsfs_pkg::WORD_W-1:0]         cfg_data
);

  lsfs_pkg::lsfs_cmd_t  cmd;
  lsfs_pkg::lsfs_stat_t stat;

  // registers are always writable
  assign cfg_ready = 1'b1;

  // sequencer
  lsfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (command),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // store and read-out datapath
  lsfs_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .command    (command),
    .led_pos    (led_pos),
    .strip      (strip),
    .brightness (brightness),
    .color      (color),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .frame_word (frame_word),
    .frame_last (frame_last)
  );

endmodule
